[src/chs_pkg.sv]
// shared types and codes for the chained hash set
`default_nettype none
package chs_pkg;

  localparam int unsigned KeyW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic found;
    logic full_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_HEAD,
    ST_DISPATCH,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_UNLINK,
    ST_FREE,
    ST_ALLOC_RD,
    ST_ALLOC,
    ST_LINK,
    ST_TAIL_RD,
    ST_TAIL,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic div;
    logic p_head;
    logic p_free;
    logic advance;
    logic alloc;
    logic tail_link;
    logic set_head;
    logic unlink;
    logic free_node;
    logic set_found;
    logic set_full;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       div_last;
    logic [1:0] cmd;
    logic       head_null;
    logic       p_null;
    logic       link_null;
    logic       key_match;
    logic       free_null;
  } sts_t;

endpackage
`default_nettype wire

[src/chs_ctrl.sv]
// controller state machine for the chained hash set
`default_nettype none
module chs_ctrl
  import chs_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy_o,
  output logic done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (start_i) state_d = ST_DIV;
      ST_DIV:      if (sts_i.div_last) state_d = ST_HEAD;
      ST_HEAD:     state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_INSERT: state_d = sts_i.free_null ? ST_DONE : ST_ALLOC_RD;
          CMD_REMOVE, CMD_SEARCH: state_d = ST_WALK_RD;
          default: state_d = ST_DONE;
        endcase
      end
      ST_WALK_RD:  state_d = sts_i.p_null ? ST_DONE : ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (!sts_i.key_match) state_d = ST_WALK_RD;
        else if (sts_i.cmd == CMD_REMOVE) state_d = ST_UNLINK;
        else state_d = ST_DONE;
      end
      ST_UNLINK:   state_d = ST_FREE;
      ST_FREE:     state_d = ST_DONE;
      ST_ALLOC_RD: state_d = ST_ALLOC;
      ST_ALLOC:    state_d = ST_LINK;
      ST_LINK:     state_d = sts_i.head_null ? ST_DONE : ST_TAIL_RD;
      ST_TAIL_RD:  state_d = ST_TAIL;
      ST_TAIL:     state_d = sts_i.link_null ? ST_DONE : ST_TAIL_RD;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:    ctl_o.clr = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        ctl_o.load = start_i;
      end
      ST_DIV:      ctl_o.div = 1'b1;
      ST_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_INSERT: begin
            ctl_o.set_full = sts_i.free_null;
            ctl_o.p_free   = !sts_i.free_null;
          end
          CMD_REMOVE, CMD_SEARCH: ctl_o.p_head = 1'b1;
          default: ;
        endcase
      end
      ST_WALK_CMP: begin
        ctl_o.advance   = !sts_i.key_match;
        ctl_o.set_found = sts_i.key_match && (sts_i.cmd == CMD_SEARCH);
      end
      ST_UNLINK:   ctl_o.unlink = 1'b1;
      ST_FREE: begin
        ctl_o.free_node = 1'b1;
        ctl_o.set_found = 1'b1;
      end
      ST_ALLOC:    ctl_o.alloc = 1'b1;
      ST_LINK: begin
        ctl_o.set_head = sts_i.head_null;
        ctl_o.p_head   = !sts_i.head_null;
      end
      ST_TAIL: begin
        ctl_o.tail_link = sts_i.link_null;
        ctl_o.advance   = !sts_i.link_null;
      end
      ST_DONE:     done_o = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/chs_dp.sv]
// datapath: modulo unit, bucket heads, node pool and free list
`default_nettype none
module chs_dp
  import chs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 16,
  parameter int unsigned POOL_NODES  = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  req_t       req_i,
  input  wire  [4:0] bucket_count_i,
  input  ctl_t       ctl_i,
  output sts_t       sts_o,
  output res_t       res_o
);

  localparam int unsigned NW = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned LW = $clog2(POOL_NODES + 1);
  localparam int unsigned IW = $clog2(POOL_NODES);
  localparam int unsigned EW = (NW > 5) ? NW : 5;
  localparam logic [LW-1:0] Nil = LW'(POOL_NODES);
  localparam logic [BW-1:0] LastBkt = BW'(MAX_BUCKETS - 1);

  logic [LW-1:0]   head_mem [MAX_BUCKETS];
  logic [KeyW-1:0] key_mem  [POOL_NODES];
  logic [LW-1:0]   link_mem [POOL_NODES];

  logic [1:0]      cmd_q;
  logic [KeyW-1:0] key_q, div_q;
  logic [4:0]      cnt_q;
  logic [NW-1:0]   rem_q;
  logic [BW-1:0]   clr_q;
  logic [LW-1:0]   p_q, prev_q, n_q, free_q, fresh_q;
  logic [LW-1:0]   head_rd_q, link_rd_q;
  logic [KeyW-1:0] key_rd_q;
  logic            found_q, full_q;

  // effective divisor: zero counts as one, saturate at the bucket limit
  logic [EW-1:0] bc_ext;
  logic [NW-1:0] dvs;
  logic [NW:0]   trial;
  logic [NW-1:0] rem_d;

  assign bc_ext = EW'(bucket_count_i);

  always_comb begin
    if (bc_ext == '0) dvs = NW'(1);
    else if (bc_ext > EW'(MAX_BUCKETS)) dvs = NW'(MAX_BUCKETS);
    else dvs = NW'(bc_ext);
    trial = {rem_q, div_q[KeyW-1]};
    if (trial >= {1'b0, dvs}) rem_d = NW'(trial - {1'b0, dvs});
    else rem_d = trial[NW-1:0];
  end

  logic [BW-1:0] bkt;
  assign bkt = BW'(rem_q);

  // bucket head memory, one write port
  logic          hw_en;
  logic [BW-1:0] hw_addr;
  logic [LW-1:0] hw_data;

  always_comb begin
    hw_en   = 1'b0;
    hw_addr = bkt;
    hw_data = n_q;
    if (ctl_i.clr) begin
      hw_en   = 1'b1;
      hw_addr = clr_q;
      hw_data = Nil;
    end else if (ctl_i.set_head) begin
      hw_en = 1'b1;
    end else if (ctl_i.unlink && prev_q == Nil) begin
      hw_en   = 1'b1;
      hw_data = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) head_mem[hw_addr] <= hw_data;
    head_rd_q <= head_mem[bkt];
  end

  // node link memory, one write port
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [LW-1:0] lw_data;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = p_q[IW-1:0];
    lw_data = Nil;
    if (ctl_i.alloc) begin
      lw_en = 1'b1;
    end else if (ctl_i.tail_link) begin
      lw_en   = 1'b1;
      lw_data = n_q;
    end else if (ctl_i.unlink && prev_q != Nil) begin
      lw_en   = 1'b1;
      lw_addr = prev_q[IW-1:0];
      lw_data = link_rd_q;
    end else if (ctl_i.free_node) begin
      lw_en   = 1'b1;
      lw_data = free_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    link_rd_q <= link_mem[p_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) key_mem[p_q[IW-1:0]] <= key_q;
    key_rd_q <= key_mem[p_q[IW-1:0]];
  end

  // free list: recycled nodes first, then the never used tail of the pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '0;
      fresh_q <= '0;
      clr_q   <= '0;
    end else begin
      if (ctl_i.clr) clr_q <= clr_q + BW'(1);
      if (ctl_i.alloc) begin
        if (p_q == fresh_q) begin
          free_q  <= fresh_q + LW'(1);
          fresh_q <= fresh_q + LW'(1);
        end else begin
          free_q <= link_rd_q;
        end
      end else if (ctl_i.free_node) begin
        free_q <= p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= req_i.command;
      key_q   <= req_i.key;
      div_q   <= req_i.key;
      cnt_q   <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
    end
    if (ctl_i.div) begin
      rem_q <= rem_d;
      div_q <= {div_q[KeyW-2:0], 1'b0};
      cnt_q <= cnt_q + 5'd1;
    end
    if (ctl_i.p_head) begin
      p_q    <= head_rd_q;
      prev_q <= Nil;
    end
    if (ctl_i.p_free) p_q <= free_q;
    if (ctl_i.advance) begin
      prev_q <= p_q;
      p_q    <= link_rd_q;
    end
    if (ctl_i.alloc) n_q <= p_q;
    if (ctl_i.set_found) found_q <= 1'b1;
    if (ctl_i.set_full) full_q <= 1'b1;
  end

  always_comb begin
    sts_o.clr_last  = (clr_q == LastBkt);
    sts_o.div_last  = (cnt_q == 5'd31);
    sts_o.cmd       = cmd_q;
    sts_o.head_null = (head_rd_q == Nil);
    sts_o.p_null    = (p_q == Nil);
    sts_o.link_null = (link_rd_q == Nil);
    sts_o.key_match = (key_rd_q == key_q);
    sts_o.free_null = (free_q == Nil);
  end

  assign res_o.found    = found_q;
  assign res_o.full_res = full_q;

endmodule
`default_nettype wire

[src/chained_hash_set.sv]
// a request runs the bit-serial modulo unit, reads its bucket head, then steps along the chain
// with one node memory read per step: a search or remove stops at a hit or at the chain end,
// a remove hit then unlinks and frees the node, an insert takes a free node and walks to the
// chain tail, and an insert refused on a full pool ends after the head read; busy drops
// after done_o, so a new item is taken only once the last one is done; results cannot be stalled
// reset: a clearing pass over every bucket head (busy high), bucket_count 7, full free list
`default_nettype none
module chained_hash_set
  import chs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 16,
  parameter int unsigned POOL_NODES  = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command side
  input  wire         start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output res_t        res_o,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // bucket_count register, the only register, at byte address 0
  logic [4:0] bc_q, bc_d;

  always_comb begin
    bc_d = bc_q;
    if (psel && penable && pwrite && paddr[1:0] == 2'b00) bc_d = pwdata[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= 5'd7;
    end else begin
      bc_q <= bc_d;
    end
  end

  assign prdata = {27'd0, bc_q};
  assign pready = 1'b1;

  ctl_t ctl;
  sts_t sts;

  // sequencer: clear pass, modulo, chain walk, link updates
  chs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // storage and arithmetic
  chs_dp #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .bucket_count_i(bc_q),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .res_o         (res_o)
  );

endmodule
`default_nettype wire

[tb/chained_hash_set_tb.sv]
// self-checking testbench for the chained hash set: queued driver, strobe monitor, own predictor
`default_nettype none
module chained_hash_set_tb;
  import chs_pkg::*;

  localparam int unsigned NBUCK = 16;
  localparam int unsigned NPOOL = 64;
  localparam int unsigned NIL   = NPOOL;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam logic [1:0]  CMD_BAD = 2'd3;   // unused command code
  localparam logic [1:0]  ADDR_BUCKETS = 2'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  res_t        res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chained_hash_set uut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .req_i(req),
    .done_o(done), .res_o(res), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state, a shadow of the table
  logic [4:0]  shadow_buckets;
  int unsigned head_of [NBUCK];
  logic [31:0] key_of [NPOOL];
  int unsigned link_of [NPOOL];
  int unsigned free_top;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   gap_left = 0;
  int   remove_keys[$];   // keys believed present, fed back into later requests of every kind

  function automatic int unsigned bucket_for(logic [31:0] key);
    int unsigned n;
    n = shadow_buckets;
    if (n == 0) n = 1;
    if (n > NBUCK) n = NBUCK;
    return key % n;
  endfunction

  // one request against the shadow table, returns the outcome
  function automatic res_t table_apply(req_t r);
    res_t o;
    int unsigned b, p, prev, n, steps;
    o = '0;
    b = bucket_for(r.key);
    case (r.command)
      CMD_INSERT: begin
        n = free_top;
        if (n >= NPOOL) begin
          o.full_res = 1'b1;
        end else begin
          free_top = link_of[n];
          key_of[n] = r.key;
          link_of[n] = NIL;
          p = head_of[b];
          if (p >= NPOOL) begin
            head_of[b] = n;
          end else begin
            for (steps = 0; steps < NPOOL && link_of[p] < NPOOL; steps++) p = link_of[p];
            link_of[p] = n;
          end
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        p = head_of[b];
        prev = NIL;
        for (steps = 0; steps < NPOOL && p < NPOOL; steps++) begin
          if (key_of[p] == r.key) begin
            o.found = 1'b1;
            if (r.command == CMD_REMOVE) begin
              if (prev < NPOOL) link_of[prev] = link_of[p];
              else head_of[b] = link_of[p];
              link_of[p] = free_top;
              free_top = p;
            end
            break;
          end
          prev = p;
          p = link_of[p];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  // driver: start held until the block takes the item
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_res.push_back(table_apply(req));
      if (pending_reqs.size() > 0 && short_or_long_gap() == 0) begin
        req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
        gap_left <= short_or_long_gap();
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: every done strobe is one result item
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_res.size() == 0) begin
        $error("result with nothing expected: found=%0b full_res=%0b", res.found, res.full_res);
        errors++;
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (res.found !== e.found) begin
          $error("found: expected %0b actual %0b", e.found, res.found);
          errors++;
        end
        if (res.full_res !== e.full_res) begin
          $error("full_res: expected %0b actual %0b", e.full_res, res.full_res);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles where nothing is accepted
  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_buckets(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_BUCKETS; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_buckets = v[4:0];
  endtask

  // wait until the queue is drained and every expected result arrived
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_res.size() > 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic void add(logic [1:0] c, logic [31:0] k);
    req_t r;
    r.command = c;
    r.key = k;
    pending_reqs.push_back(r);
    if (c == CMD_INSERT && remove_keys.size() < 200) remove_keys.push_back(k);
  endfunction

  function automatic logic [31:0] some_key();
    if (remove_keys.size() > 0 && $urandom_range(0, 1)) return remove_keys[$urandom_range(0, remove_keys.size() - 1)];
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 40);
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    int i, roll;
    logic [1:0] c;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) c = CMD_INSERT;
      else if (roll < 70) c = CMD_REMOVE;
      else if (roll < 97) c = CMD_SEARCH;
      else c = CMD_BAD;
      add(c, some_key());
    end
  endtask

  initial begin
    int i;
    shadow_buckets = 5'd7;
    for (i = 0; i < NBUCK; i++) head_of[i] = NIL;
    for (i = 0; i < NPOOL; i++) begin
      key_of[i] = '0;
      link_of[i] = i + 1;
    end
    free_top = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset bucket count, key extremes, absent removes, bad command
    add(CMD_SEARCH, 32'h0);
    add(CMD_REMOVE, 32'hFFFF_FFFF);
    add(CMD_INSERT, 32'h0);
    add(CMD_INSERT, 32'hFFFF_FFFF);
    add(CMD_INSERT, 32'hFFFF_FFFF);     // duplicate
    add(CMD_INSERT, 32'd7);              // same bucket as key zero
    add(CMD_SEARCH, 32'hFFFF_FFFF);
    add(CMD_REMOVE, 32'hFFFF_FFFF);
    add(CMD_SEARCH, 32'hFFFF_FFFF);     // second copy still there
    add(CMD_REMOVE, 32'h0);              // head of a chain
    add(CMD_SEARCH, 32'd7);
    add(CMD_BAD, 32'd7);
    add(CMD_SEARCH, 32'hAAAA_5555);
    drain();

    // zero count behaves as one bucket, stale chains stay where they were
    write_buckets(32'd0);
    add(CMD_SEARCH, 32'd7);
    add(CMD_INSERT, 32'h5555_AAAA);
    add(CMD_SEARCH, 32'h5555_AAAA);
    drain();

    // fill the pool to exhaustion in one bucket
    write_buckets(32'd1);
    for (i = 0; i < NPOOL + 3; i++) add(CMD_INSERT, $urandom());
    add(CMD_REMOVE, 32'h5555_AAAA);
    add(CMD_INSERT, 32'h1234_5678);
    add(CMD_INSERT, 32'h1234_5679);
    drain();
    // empty it again
    while (remove_keys.size() > 0) add(CMD_REMOVE, remove_keys.pop_back());
    drain();

    write_buckets(32'd16);
    random_phase(250);
    drain();
    write_buckets(32'd31);              // saturates to the maximum
    random_phase(250);
    drain();
    write_buckets(32'hFFFF_FFE3);       // upper bits ignored, count 3
    random_phase(250);
    drain();
    write_buckets($urandom_range(1, 16));
    random_phase(250);
    drain();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
